### rtl/sopb_pkg.sv
// ----------------------------------------------------------------------------
// sopb_pkg
// Shared types and constants of the sequence ordered packet buffer.
// ----------------------------------------------------------------------------
package sopb_pkg;

    // Default number of descriptors held.
    localparam int DEPTH_DEFAULT = 128;

    // Field widths fixed by the descriptor format.
    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 12;
    localparam int SENT_W = 32;
    localparam int TAG_W  = 8;
    localparam int OCC_W  = 8;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 3;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_QUERY   = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ENQ_READ,
        S_ENQ_CMP,
        S_HEAD_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  length;
        logic [SENT_W-1:0] sent_at;
        logic [TAG_W-1:0]  tag;
    } t_desc;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the accepted item
        logic set_full;   // enqueue dropped
        logic set_empty;  // dequeue or peek with nothing held
        logic rd_head;    // read the head entry
        logic rd_prev;    // read the entry just below the insert position
        logic shift_wr;   // move the entry read up by one place
        logic ins_wr;     // write the new descriptor at the insert position
        logic take_head;  // the head read is reported
        logic deq;        // drop the head entry
        logic res_load;   // load the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_command command;
        logic     empty;
        logic     full;
        logic     pos_zero;
        logic     less;
        logic     out_free;
    } t_ctrl_stat;

endpackage

### rtl/sopb_ctrl.sv
// ----------------------------------------------------------------------------
// sopb_ctrl
// Controller of the packet buffer: steps each item through decode, the
// insertion walk or the head read, and the result hand-off.
// ----------------------------------------------------------------------------
module sopb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sopb_pkg::t_ctrl_stat i_stat,
    output sopb_pkg::t_ctrl_cmd  o_cmd
);

    sopb_pkg::t_state r_state;
    sopb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sopb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sopb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = sopb_pkg::S_DECODE;
                end
            end
            sopb_pkg::S_DECODE: begin
                case (i_stat.command)
                    sopb_pkg::CMD_ENQUEUE: begin
                        n_state = i_stat.full ? sopb_pkg::S_RESULT : sopb_pkg::S_ENQ_READ;
                    end
                    sopb_pkg::CMD_DEQUEUE, sopb_pkg::CMD_PEEK: begin
                        n_state = i_stat.empty ? sopb_pkg::S_RESULT : sopb_pkg::S_HEAD_WAIT;
                    end
                    default: begin
                        n_state = sopb_pkg::S_RESULT;
                    end
                endcase
            end
            sopb_pkg::S_ENQ_READ: begin
                n_state = i_stat.pos_zero ? sopb_pkg::S_RESULT : sopb_pkg::S_ENQ_CMP;
            end
            sopb_pkg::S_ENQ_CMP: begin
                n_state = i_stat.less ? sopb_pkg::S_ENQ_READ : sopb_pkg::S_RESULT;
            end
            sopb_pkg::S_HEAD_WAIT: begin
                n_state = sopb_pkg::S_RESULT;
            end
            sopb_pkg::S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = sopb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sopb_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs. No item is taken while reset is held.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sopb_pkg::S_IDLE: begin
                o_in_ready  = i_rst_n;
                o_cmd.latch = i_in_valid && i_rst_n;
            end
            sopb_pkg::S_DECODE: begin
                case (i_stat.command)
                    sopb_pkg::CMD_ENQUEUE: begin
                        o_cmd.set_full = i_stat.full;
                    end
                    sopb_pkg::CMD_DEQUEUE, sopb_pkg::CMD_PEEK: begin
                        o_cmd.set_empty = i_stat.empty;
                        o_cmd.rd_head   = !i_stat.empty;
                    end
                    default: begin
                    end
                endcase
            end
            sopb_pkg::S_ENQ_READ: begin
                o_cmd.ins_wr  = i_stat.pos_zero;
                o_cmd.rd_prev = !i_stat.pos_zero;
            end
            sopb_pkg::S_ENQ_CMP: begin
                o_cmd.shift_wr = i_stat.less;
                o_cmd.ins_wr   = !i_stat.less;
            end
            sopb_pkg::S_HEAD_WAIT: begin
                o_cmd.take_head = 1'b1;
                o_cmd.deq       = (i_stat.command == sopb_pkg::CMD_DEQUEUE);
            end
            sopb_pkg::S_RESULT: begin
                o_cmd.res_load = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/sopb_datapath.sv
// ----------------------------------------------------------------------------
// sopb_datapath
// Descriptor memory kept as a sorted circular list, its pointers, the
// insertion compare and the output register.
// ----------------------------------------------------------------------------
module sopb_datapath #(
    parameter int DEPTH = sopb_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sopb_pkg::t_command          i_command,
    input  sopb_pkg::t_desc             i_desc,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output sopb_pkg::t_status           o_status,
    output logic                        o_head_valid,
    output sopb_pkg::t_desc             o_head,
    output logic [sopb_pkg::OCC_W-1:0]  o_occupancy,
    output logic                        o_is_empty,
    output logic                        o_is_full,
    input  sopb_pkg::t_ctrl_cmd         i_cmd,
    output sopb_pkg::t_ctrl_stat        o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sopb_pkg::t_desc    mem [DEPTH];
    sopb_pkg::t_desc    r_rd_data;
    sopb_pkg::t_desc    r_item;
    sopb_pkg::t_command r_command;
    sopb_pkg::t_status  r_status;
    logic               r_head_valid;
    logic [AW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_pos;

    logic               r_out_valid;
    sopb_pkg::t_status  r_out_status;
    logic               r_out_head_valid;
    sopb_pkg::t_desc    r_out_head;
    logic [CW-1:0]      r_out_count;

    logic [CW-1:0]      rd_logical;
    logic [CW:0]        rd_sum;
    logic [CW:0]        wr_sum;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    sopb_pkg::t_desc    wr_data;
    logic               count_full;
    logic               out_free;

    // Logical place to physical address: one add and one wrap correction.
    assign rd_logical = i_cmd.rd_head ? '0 : (r_pos - 1'b1);
    assign rd_sum     = (CW+1)'(r_head) + (CW+1)'(rd_logical);
    assign wr_sum     = (CW+1)'(r_head) + (CW+1)'(r_pos);
    assign rd_addr    = (rd_sum >= (CW+1)'(DEPTH)) ? AW'(rd_sum - (CW+1)'(DEPTH)) : AW'(rd_sum);
    assign wr_addr    = (wr_sum >= (CW+1)'(DEPTH)) ? AW'(wr_sum - (CW+1)'(DEPTH)) : AW'(wr_sum);
    assign wr_en      = i_cmd.shift_wr || i_cmd.ins_wr;
    assign wr_data    = i_cmd.shift_wr ? r_rd_data : r_item;
    assign count_full = (r_count == CW'(DEPTH));
    assign out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_head || i_cmd.rd_prev) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Item context.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item       <= i_desc;
            r_command    <= i_command;
            r_status     <= sopb_pkg::ST_OK;
            r_head_valid <= 1'b0;
            r_pos        <= r_count;
        end else begin
            if (i_cmd.set_full) begin
                r_status <= sopb_pkg::ST_FULL;
            end
            if (i_cmd.set_empty) begin
                r_status <= sopb_pkg::ST_EMPTY;
            end
            if (i_cmd.take_head) begin
                r_head_valid <= 1'b1;
            end
            if (i_cmd.shift_wr) begin
                r_pos <= r_pos - 1'b1;
            end
        end
    end

    // List pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.ins_wr) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.deq) begin
                r_count <= r_count - 1'b1;
                r_head  <= (r_head == AW'(DEPTH - 1)) ? '0 : (r_head + 1'b1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_status     <= r_status;
            r_out_head_valid <= r_head_valid;
            r_out_head       <= r_head_valid ? r_rd_data : '0;
            r_out_count      <= r_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_head_valid = r_out_head_valid;
    assign o_head       = r_out_head;
    assign o_occupancy  = sopb_pkg::OCC_W'(r_out_count);
    assign o_is_empty   = (r_out_count == '0);
    assign o_is_full    = (r_out_count == CW'(DEPTH));

    assign o_stat.command  = r_command;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = count_full;
    assign o_stat.pos_zero = (r_pos == '0);
    assign o_stat.less     = (r_item.seq < r_rd_data.seq);
    assign o_stat.out_free = out_free;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_pos <= r_count))
        else $error("insert position beyond the held entries");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |-> !count_full)
        else $error("insert into a full buffer");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.deq |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not lower the count by one");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> out_free)
        else $error("result loaded over an untaken result");
`endif

endmodule

### rtl/sequence_ordered_packet_buffer.sv
// ----------------------------------------------------------------------------
// sequence_ordered_packet_buffer
// Reorder buffer for packet descriptors, kept sorted by sequence number.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH descriptors in ascending sequence-number order
// and takes one command item at a time: enqueue inserts the descriptor after
// every held entry with an equal or smaller number (or drops it and reports
// full), dequeue removes and reports the head, peek reports the head and
// leaves it, and a status query reports only the count and flags. Every item
// gives exactly one result item. The entries live in a single-port-write,
// single-read memory used as a circular list, so dequeue only advances a head
// pointer, while enqueue walks down from the tail one entry per read, moving
// each larger entry up one place. Each item goes from idle to decode; a
// status query or a refused command then goes straight to the result state,
// a dequeue or a peek reads the head on the way, and an enqueue alternates a
// registered memory read of the entry below the insert position with the
// compare against the new sequence number, until that entry is not larger
// or the insert position reaches the head. The result state waits for a free
// output register, loads it and returns to idle. A result waits in an output
// register, and the next item is accepted as soon as the controller is back
// in idle, even if that result has not yet been taken. The memory needs no
// clearing after reset: only entries below the count are ever read.
module sequence_ordered_packet_buffer #(
    parameter int DEPTH = sopb_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave side: tuser = command[1:0].
    // tdata, lowest bit up: seq_number[31:0], data_length[11:0], sent_at[31:0],
    // payload_tag[7:0], zero fill to 88 bits.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [sopb_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  logic [1:0]                          i_s_axis_tuser,
    // Master side: tuser, lowest bit up: status[1:0], head_valid.
    // tdata, lowest bit up: head_seq[31:0], head_length[11:0], head_sent_at[31:0],
    // head_tag[7:0], occupancy[7:0], is_empty, is_full, zero fill to 96 bits.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [sopb_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic [sopb_pkg::OUT_USER_W-1:0]     o_m_axis_tuser
);

    sopb_pkg::t_ctrl_cmd           ctrl_cmd;
    sopb_pkg::t_ctrl_stat          ctrl_stat;
    sopb_pkg::t_desc               in_desc;
    sopb_pkg::t_status             out_status;
    logic                          out_head_valid;
    sopb_pkg::t_desc               out_head;
    logic [sopb_pkg::OCC_W-1:0]    out_occupancy;
    logic                          out_is_empty;
    logic                          out_is_full;

    // Unpack the incoming descriptor.
    assign in_desc.seq     = i_s_axis_tdata[31:0];
    assign in_desc.length  = i_s_axis_tdata[43:32];
    assign in_desc.sent_at = i_s_axis_tdata[75:44];
    assign in_desc.tag     = i_s_axis_tdata[83:76];

    sopb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (ctrl_stat),
        .o_cmd      (ctrl_cmd)
    );

    sopb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_command    (sopb_pkg::t_command'(i_s_axis_tuser)),
        .i_desc       (in_desc),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_status     (out_status),
        .o_head_valid (out_head_valid),
        .o_head       (out_head),
        .o_occupancy  (out_occupancy),
        .o_is_empty   (out_is_empty),
        .o_is_full    (out_is_full),
        .i_cmd        (ctrl_cmd),
        .o_stat       (ctrl_stat)
    );

    // Pack the result item.
    assign o_m_axis_tuser = {out_head_valid, out_status};
    assign o_m_axis_tdata = {2'b00, out_is_full, out_is_empty, out_occupancy,
                             out_head.tag, out_head.sent_at, out_head.length,
                             out_head.seq};

endmodule
